FILE: hdl/ogbu_pkg.sv
`timescale 1ns / 1ps
package ogbu_pkg;

    // screen and cell limits
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 600;
    localparam int MAX_CELL_SIZE = 16;
    localparam int SPAN_CAP      = 16;
    localparam int COUNTER_CAP   = 1024;

    localparam int CELL_CAP = (MAX_CELL_SIZE < SPAN_CAP) ? MAX_CELL_SIZE : SPAN_CAP;
    localparam int W_HI     = (SCREEN_WIDTH  < COUNTER_CAP) ? SCREEN_WIDTH  : COUNTER_CAP;
    localparam int H_HI     = (SCREEN_HEIGHT < COUNTER_CAP) ? SCREEN_HEIGHT : COUNTER_CAP;

    // field widths
    localparam int MW_W    = 11;
    localparam int MH_W    = 10;
    localparam int CNT_W   = 10;
    localparam int CS_W    = 5;
    localparam int VAL_W   = 8;
    localparam int ADDR_W  = 20;
    localparam int COLOR_W = 16;
    localparam int LEN_W   = 5;
    localparam int SCR_W   = $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                     SCREEN_WIDTH : SCREEN_HEIGHT) + 1);
    localparam int PROD_W  = MW_W + CS_W;
    localparam int CMP_W   = (PROD_W > SCR_W) ? PROD_W : SCR_W;

    // APB
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // occupancy classes
    localparam logic [VAL_W-1:0]   BLACK_MIN    = 8'd254;
    localparam logic [VAL_W-1:0]   DARK_MIN     = 8'd200;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 16'h0000;
    localparam logic [COLOR_W-1:0] COLOR_DARK   = 16'h4208;
    localparam logic [COLOR_W-1:0] COLOR_LIGHT  = 16'h8410;

    typedef struct packed {
        logic take_cell;
        logic search_init;
        logic search_step;
        logic search_done;
        logic offset_load;
        logic base_load;
        logic prep_load;
        logic span_load;
    } ogbu_cmd_t;

    typedef struct packed {
        logic map_start;
        logic fits;
        logic cand_is_one;
        logic span_last;
        logic out_free;
    } ogbu_stat_t;

    function automatic logic [COLOR_W-1:0] class_color(input logic [VAL_W-1:0] v);
        logic [COLOR_W-1:0] c;
        if (v == '0) begin
            c = COLOR_WHITE;
        end else if (v >= BLACK_MIN) begin
            c = COLOR_BLACK;
        end else if (v >= DARK_MIN) begin
            c = COLOR_DARK;
        end else begin
            c = COLOR_LIGHT;
        end
        return c;
    endfunction

endpackage

FILE: hdl/ogbu_ctrl.sv
`timescale 1ns / 1ps
module ogbu_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ogbu_pkg::ogbu_stat_t stat,
    output ogbu_pkg::ogbu_cmd_t  cmd
);
    import ogbu_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_OFFSET = 3'd2;
    localparam logic [2:0] ST_BASE   = 3'd3;
    localparam logic [2:0] ST_PREP   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_cell = 1'b1;
                    if (stat.map_start) begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SEARCH;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_SEARCH: begin
                // largest candidate size that fits both axes wins
                if (stat.fits || stat.cand_is_one) begin
                    cmd.search_done = 1'b1;
                    state_next      = ST_OFFSET;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_OFFSET: begin
                cmd.offset_load = 1'b1;
                state_next      = ST_BASE;
            end
            ST_BASE: begin
                cmd.base_load = 1'b1;
                state_next    = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.span_load = 1'b1;
                    if (stat.span_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/ogbu_datapath.sv
`timescale 1ns / 1ps
module ogbu_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ogbu_pkg::MW_W-1:0]        map_width,
    input  logic [ogbu_pkg::MH_W-1:0]        map_height,
    input  logic [ogbu_pkg::VAL_W-1:0]       s_cell_value,
    input  ogbu_pkg::ogbu_cmd_t              cmd,
    output ogbu_pkg::ogbu_stat_t             stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ogbu_pkg::ADDR_W-1:0]      m_pixel_address,
    output logic [ogbu_pkg::COLOR_W-1:0]     m_pixel_color,
    output logic [ogbu_pkg::LEN_W-1:0]       m_span_length,
    output logic                             m_last_span,
    output logic                             m_map_done
);
    import ogbu_pkg::*;

    // effective (saturated) map size
    logic [MW_W-1:0] w_eff;
    logic [MW_W-1:0] h_eff;
    logic [MW_W-1:0] h_ext;

    // position and transform state
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CS_W-1:0]   cs_reg;
    logic [CS_W-1:0]   cand_reg;
    logic [SCR_W-1:0]  x_off_reg;
    logic [SCR_W-1:0]  y_off_reg;
    logic [ADDR_W-1:0] y_base_reg;
    logic [ADDR_W-1:0] row_base_reg;

    // per-cell working registers
    logic [COLOR_W-1:0] color_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CS_W-1:0]    k_reg;
    logic               last_col_reg;
    logic               last_row_reg;

    logic [PROD_W-1:0]       cand_w;
    logic [PROD_W-1:0]       cand_h;
    logic [PROD_W-1:0]       used_w;
    logic [PROD_W-1:0]       used_h;
    logic [CMP_W-1:0]        free_w;
    logic [CMP_W-1:0]        free_h;
    logic [2*SCR_W-1:0]      y_base_full;
    logic [CNT_W+CS_W-1:0]   col_px;
    logic [ADDR_W-1:0]       first_addr;
    logic [ADDR_W-1:0]       row_step;
    logic [MW_W-1:0]         col_inc;
    logic [MW_W-1:0]         row_inc;
    logic [CS_W:0]           k_inc;

    assign h_ext = MW_W'(map_height);

    always_comb begin
        if (map_width == '0) begin
            w_eff = MW_W'(1);
        end else if (map_width > MW_W'(W_HI)) begin
            w_eff = MW_W'(W_HI);
        end else begin
            w_eff = map_width;
        end
        if (h_ext == '0) begin
            h_eff = MW_W'(1);
        end else if (h_ext > MW_W'(H_HI)) begin
            h_eff = MW_W'(H_HI);
        end else begin
            h_eff = h_ext;
        end
    end

    // size search: one candidate per cycle, counting down
    assign cand_w = PROD_W'(w_eff) * PROD_W'(cand_reg);
    assign cand_h = PROD_W'(h_eff) * PROD_W'(cand_reg);
    assign used_w = PROD_W'(w_eff) * PROD_W'(cs_reg);
    assign used_h = PROD_W'(h_eff) * PROD_W'(cs_reg);
    assign free_w = CMP_W'(SCREEN_WIDTH)  - CMP_W'(used_w);
    assign free_h = CMP_W'(SCREEN_HEIGHT) - CMP_W'(used_h);

    assign y_base_full = (2*SCR_W)'(y_off_reg) * (2*SCR_W)'(SCREEN_WIDTH);
    assign col_px      = (CNT_W+CS_W)'(col_reg) * (CNT_W+CS_W)'(cs_reg);
    assign first_addr  = row_base_reg + ADDR_W'(x_off_reg) + ADDR_W'(col_px);
    assign row_step    = ADDR_W'(cs_reg) * ADDR_W'(SCREEN_WIDTH);
    assign col_inc     = MW_W'(col_reg) + MW_W'(1);
    assign row_inc     = MW_W'(row_reg) + MW_W'(1);
    assign k_inc       = {1'b0, k_reg} + (CS_W + 1)'(1);

    assign stat.map_start   = (col_reg == '0) && (row_reg == '0);
    assign stat.fits        = (CMP_W'(cand_w) <= CMP_W'(SCREEN_WIDTH)) &&
                              (CMP_W'(cand_h) <= CMP_W'(SCREEN_HEIGHT));
    assign stat.cand_is_one = (cand_reg == CS_W'(1));
    assign stat.span_last   = (k_inc == {1'b0, cs_reg});
    assign stat.out_free    = !m_valid || m_ready;

    // transform and position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            cs_reg       <= CS_W'(1);
            x_off_reg    <= '0;
            y_off_reg    <= '0;
            y_base_reg   <= '0;
            row_base_reg <= '0;
        end else begin
            if (cmd.search_done) begin
                cs_reg <= cand_reg;
            end
            if (cmd.offset_load) begin
                x_off_reg <= SCR_W'(free_w >> 1);
                y_off_reg <= SCR_W'(free_h >> 1);
            end
            if (cmd.base_load) begin
                y_base_reg   <= y_base_full[ADDR_W-1:0];
                row_base_reg <= y_base_full[ADDR_W-1:0];
            end
            if (cmd.span_load && stat.span_last) begin
                if (last_col_reg) begin
                    col_reg <= '0;
                    if (last_row_reg) begin
                        row_reg      <= '0;
                        row_base_reg <= y_base_reg;
                    end else begin
                        row_reg      <= row_reg + CNT_W'(1);
                        row_base_reg <= row_base_reg + row_step;
                    end
                end else begin
                    col_reg <= col_reg + CNT_W'(1);
                end
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.take_cell) begin
            color_reg <= class_color(s_cell_value);
        end
        if (cmd.search_init) begin
            cand_reg <= CS_W'(CELL_CAP);
        end else if (cmd.search_step) begin
            cand_reg <= cand_reg - CS_W'(1);
        end
        if (cmd.prep_load) begin
            addr_reg     <= first_addr;
            k_reg        <= '0;
            last_col_reg <= (col_inc >= w_eff);
            last_row_reg <= (row_inc >= h_eff);
        end else if (cmd.span_load) begin
            addr_reg <= addr_reg + ADDR_W'(SCREEN_WIDTH);
            k_reg    <= k_inc[CS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.span_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.span_load) begin
            m_pixel_address <= addr_reg;
            m_pixel_color   <= color_reg;
            m_span_length   <= LEN_W'(cs_reg);
            m_last_span     <= stat.span_last;
            m_map_done      <= last_col_reg && last_row_reg;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.span_load |-> (!m_valid || m_ready))
        else $error("span loaded over an untaken transfer");

    a_span_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_span_length != '0) && (m_span_length <= LEN_W'(CELL_CAP)))
        else $error("span length out of range");

    a_cell_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cs_reg != '0) && (cs_reg <= CS_W'(CELL_CAP)))
        else $error("cell size out of range");

endmodule

FILE: hdl/occupancy_grid_block_upscaler.sv
`timescale 1ns / 1ps
// Occupancy grid block upscaler.
// Input channel (s_valid/s_ready, s_cell_value): one occupancy byte per
// transfer, row-major. Output channel (m_valid/m_ready): one horizontal span
// per transfer: framebuffer address, RGB565 color, length, last-span and
// map-done flags. Each cell yields cell_size spans, top row first.
// APB port: map_width at 0x0, map_height at 0x4; write only while idle.
// Sequencing: one cell at a time. A cell that is not the first of the map
// passes through accept, address prep and span emission, one span per cycle
// while the receiver is free. The first cell of a map also runs the size
// search, one candidate per cycle counting down from 16, and then loads the
// offsets and the row base.
// Reset (synchronous, aresetn low) returns map size to 1x1, counters to the
// map origin, cell size to 1, and drops any span in flight.
// A stalled receiver holds the output register; the sequencer waits in the
// emit state and s_ready stays low until the cell's last span is loaded.
module occupancy_grid_block_upscaler (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ogbu_pkg::PADDR_W-1:0]     paddr,
    input  logic [ogbu_pkg::PDATA_W-1:0]     pwdata,
    output logic [ogbu_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // cell input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ogbu_pkg::VAL_W-1:0]       s_cell_value,
    // span output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ogbu_pkg::ADDR_W-1:0]      m_pixel_address,
    output logic [ogbu_pkg::COLOR_W-1:0]     m_pixel_color,
    output logic [ogbu_pkg::LEN_W-1:0]       m_span_length,
    output logic                             m_last_span,
    output logic                             m_map_done
);
    import ogbu_pkg::*;

    logic [MW_W-1:0] map_width_reg;
    logic [MH_W-1:0] map_height_reg;
    logic            cfg_write;
    ogbu_cmd_t       cmd;
    ogbu_stat_t      stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register file: decode on word index only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MW_W'(1);
            map_height_reg <= MH_W'(1);
        end else if (cfg_write) begin
            case (paddr[2])
                REG_MAP_WIDTH:  map_width_reg  <= pwdata[MW_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= pwdata[MH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAP_WIDTH:  prdata = PDATA_W'(map_width_reg);
            REG_MAP_HEIGHT: prdata = PDATA_W'(map_height_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer: accept, optional size search with offset and base load, prep, span emission
    ogbu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // counters, transform, address generation and output register
    ogbu_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .map_width       (map_width_reg),
        .map_height      (map_height_reg),
        .s_cell_value    (s_cell_value),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .m_span_length   (m_span_length),
        .m_last_span     (m_last_span),
        .m_map_done      (m_map_done)
    );

endmodule
